// ===== rtl/core/cca_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar clock advance package
// Shared types, operation codes and calendar arithmetic helpers.
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam logic [2:0] KIND_TICK = 3'd0;
	localparam logic [2:0] KIND_ADD  = 3'd1;
	localparam logic [2:0] KIND_TEN  = 3'd2;
	localparam logic [2:0] KIND_HOUR = 3'd3;
	localparam logic [2:0] KIND_LOAD = 3'd4;

	localparam logic [8:0] SEC_PER_MIN  = 9'd60;
	localparam logic [6:0] MIN_PER_HOUR = 7'd60;
	localparam logic [5:0] HOUR_PER_DAY = 6'd24;
	localparam logic [4:0] FEB_LEAP     = 5'd29;
	localparam logic [8:0] TEN_SEC      = 9'd10;
	localparam logic [3:0] MONTHS       = 4'd12;
	localparam logic [6:0] LAST_YEAR    = 7'd99;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} time_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] amount;
		time_t      load;
	} item_t;

	localparam time_t RESET_TIME = '{
		year: 7'd11, month: 4'd12, day: 5'd21,
		hour: 5'd21, minute: 6'd30, second: 6'd0
	};

	function automatic logic [2:0] div60(input logic [8:0] v);
		logic [2:0] q;
		q = 3'(v >= 9'd60) + 3'(v >= 9'd120) + 3'(v >= 9'd180)
			+ 3'(v >= 9'd240) + 3'(v >= 9'd300);
		return q;
	endfunction

	function automatic logic [2:0] div10(input logic [5:0] v);
		logic [2:0] q;
		q = 3'(v >= 6'd10) + 3'(v >= 6'd20) + 3'(v >= 6'd30)
			+ 3'(v >= 6'd40) + 3'(v >= 6'd50) + 3'(v >= 6'd60);
		return q;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic [6:0] yr);
		logic [4:0] len;
		case (mon) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = (yr[1:0] == 2'b00) ? FEB_LEAP : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/core/cca_intf.sv =====
// ----------------------------------------------------------------------------
// Calendar clock advance channels
// Valid/ready interfaces for the command word and the result word.
// ----------------------------------------------------------------------------
interface cca_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] amount;
	logic [6:0] load_year;
	logic [3:0] load_month;
	logic [4:0] load_day;
	logic [4:0] load_hour;
	logic [5:0] load_minute;
	logic [5:0] load_second;

	modport source (
		output valid, kind, amount, load_year, load_month, load_day,
			load_hour, load_minute, load_second,
		input ready
	);
	modport sink (
		input valid, kind, amount, load_year, load_month, load_day,
			load_hour, load_minute, load_second,
		output ready
	);
endinterface

interface cca_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] cur_year;
	logic [3:0] cur_month;
	logic [4:0] cur_day;
	logic [4:0] cur_hour;
	logic [5:0] cur_minute;
	logic [5:0] cur_second;

	modport source (
		output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
		input ready
	);
	modport sink (
		input valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
		output ready
	);
endinterface

// ===== rtl/core/calendar_clock_advance_core.sv =====
// ----------------------------------------------------------------------------
// Calendar clock advance core
// Keeps a two-digit-year calendar time and applies one command per word.
// ----------------------------------------------------------------------------
// Each word on the item channel ticks one second, adds up to 255 seconds,
// moves to the next ten-second mark, moves to the next whole hour, loads a
// new time or, for any other kind, leaves the time as it is. Every word
// returns exactly one result word on the result channel holding the time
// after the step. Both channels use valid/ready and a word moves on a clock
// edge where both are high. An accepted word is held in an input register,
// and its result is shown from the time register after it. The step logic
// is a single pass of carry arithmetic, so one word per cycle is sustained
// while the receiver takes every result.
// The time register itself is the result register. While the receiver
// stalls, the result holds, one more word waits in the input register and
// the item channel drops ready until the result is taken.
// Reset clears both stages and sets the time to year 11, month 12, day 21,
// 21:30:00.
// ----------------------------------------------------------------------------
module calendar_clock_advance_core (
	input logic          clk,
	input logic          arst_n,
	cca_item_if.sink     item,
	cca_result_if.source result
);

	logic           valid_s1;
	cca_pkg::item_t item_s1;
	logic           out_valid_q;
	cca_pkg::time_t time_q;
	cca_pkg::time_t time_next;
	logic           adv_s1;

	assign adv_s1     = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind        <= item.kind;
			item_s1.amount      <= item.amount;
			item_s1.load.year   <= item.load_year;
			item_s1.load.month  <= item.load_month;
			item_s1.load.day    <= item.load_day;
			item_s1.load.hour   <= item.load_hour;
			item_s1.load.minute <= item.load_minute;
			item_s1.load.second <= item.load_second;
		end
	end

	cca_step u_step (
		.cur (time_q),
		.itm (item_s1),
		.nxt (time_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			time_q      <= cca_pkg::RESET_TIME;
		end else begin
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				time_q      <= time_next;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.cur_year   = time_q.year;
	assign result.cur_month  = time_q.month;
	assign result.cur_day    = time_q.day;
	assign result.cur_hour   = time_q.hour;
	assign result.cur_minute = time_q.minute;
	assign result.cur_second = time_q.second;

	a_load_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.kind == cca_pkg::KIND_LOAD
		|=> time_q == $past(item_s1.load))
		else $error("loaded time did not reach the result");

	a_time_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(time_q))
		else $error("time changed without an advancing word");

	a_carry_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (item_s1.kind == cca_pkg::KIND_TICK || item_s1.kind == cca_pkg::KIND_ADD
			|| item_s1.kind == cca_pkg::KIND_TEN || item_s1.kind == cca_pkg::KIND_HOUR)
		|=> time_q.second < 6'd60 && time_q.minute < 6'd60 && time_q.hour < 5'd24)
		else $error("carry logic left a field out of range");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("waiting word was lost while the result stalled");

endmodule

// ===== rtl/core/cca_step.sv =====
// ----------------------------------------------------------------------------
// Calendar clock advance step
// Computes the calendar time that follows one command word.
// ----------------------------------------------------------------------------
module cca_step (
	input  cca_pkg::time_t cur,
	input  cca_pkg::item_t itm,
	output cca_pkg::time_t nxt
);

	logic [8:0] sec_sum;
	logic [5:0] min_in;
	logic [5:0] hr_in;
	logic [2:0] sec_q;
	logic [5:0] sec_r;
	logic [6:0] min_sum;
	logic       min_c;
	logic [5:0] min_r;
	logic [5:0] hr_sum;
	logic       hr_c;
	logic [4:0] hr_r;
	logic [5:0] day_sum;
	logic [4:0] len;
	logic       wrap;
	logic [4:0] mon_inc;
	cca_pkg::time_t norm;

	always_comb begin
		sec_sum = {3'b000, cur.second} + 9'd1;
		min_in  = cur.minute;
		hr_in   = {1'b0, cur.hour};
		case (itm.kind)
			cca_pkg::KIND_ADD: begin
				sec_sum = {3'b000, cur.second} + {1'b0, itm.amount};
			end
			cca_pkg::KIND_TEN: begin
				sec_sum = 9'(cca_pkg::div10(cur.second)) * cca_pkg::TEN_SEC
					+ cca_pkg::TEN_SEC;
			end
			cca_pkg::KIND_HOUR: begin
				sec_sum = '0;
				min_in  = '0;
				hr_in   = {1'b0, cur.hour} + 6'd1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sec_q   = cca_pkg::div60(sec_sum);
		sec_r   = 6'(sec_sum - 9'(sec_q) * cca_pkg::SEC_PER_MIN);
		min_sum = {1'b0, min_in} + 7'(sec_q);
		min_c   = (min_sum >= cca_pkg::MIN_PER_HOUR);
		min_r   = 6'(min_c ? min_sum - cca_pkg::MIN_PER_HOUR : min_sum);
		hr_sum  = hr_in + 6'(min_c);
		hr_c    = (hr_sum >= cca_pkg::HOUR_PER_DAY);
		hr_r    = 5'(hr_c ? hr_sum - cca_pkg::HOUR_PER_DAY : hr_sum);
		day_sum = {1'b0, cur.day} + 6'(hr_c);
		len     = cca_pkg::month_len(cur.month, cur.year);
		wrap    = (day_sum > {1'b0, len});
		mon_inc = {1'b0, cur.month} + 5'd1;

		norm.second = sec_r;
		norm.minute = min_r;
		norm.hour   = hr_r;
		norm.day    = 5'(wrap ? day_sum - {1'b0, len} : day_sum);
		norm.month  = cur.month;
		norm.year   = cur.year;
		if (wrap) begin
			if (mon_inc > {1'b0, cca_pkg::MONTHS}) begin
				norm.month = 4'd1;
				norm.year  = (cur.year >= cca_pkg::LAST_YEAR) ? 7'd0 : cur.year + 7'd1;
			end else begin
				norm.month = mon_inc[3:0];
			end
		end
	end

	always_comb begin
		case (itm.kind)
			cca_pkg::KIND_TICK, cca_pkg::KIND_ADD,
			cca_pkg::KIND_TEN, cca_pkg::KIND_HOUR: nxt = norm;
			cca_pkg::KIND_LOAD: nxt = itm.load;
			default: nxt = cur;
		endcase
	end

endmodule

// ===== dv/cca_calendar_checker.sv =====
// ----------------------------------------------------------------------------
// Calendar clock advance checker
// Watches the command and result channels, tracks its own copy of the
// calendar time and compares every result word with the predicted time.
// ----------------------------------------------------------------------------
module cca_calendar_checker (
	input  logic  clk,
	input  logic  arst_n,
	cca_item_if   item,
	cca_result_if result,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cca_pkg::time_t calendar_now;
	cca_pkg::time_t expected_times[$];
	int             error_total;

	function automatic cca_pkg::time_t advance_calendar(cca_pkg::time_t now,
		logic [2:0] kind, logic [7:0] amount, cca_pkg::time_t load);
		cca_pkg::time_t nxt;
		int             sec, mins, hrs, day, mon, yr, len;
		nxt  = now;
		sec  = now.second;
		mins = now.minute;
		hrs  = now.hour;
		day  = now.day;
		mon  = now.month;
		yr   = now.year;
		case (kind)
			cca_pkg::KIND_TICK: sec = sec + 1;
			cca_pkg::KIND_ADD:  sec = sec + amount;
			cca_pkg::KIND_TEN:
				sec = (sec / cca_pkg::TEN_SEC) * cca_pkg::TEN_SEC + cca_pkg::TEN_SEC;
			cca_pkg::KIND_HOUR: begin
				sec  = 0;
				mins = 0;
				hrs  = hrs + 1;
			end
			cca_pkg::KIND_LOAD: return load;
			default:            return now;
		endcase
		mins = mins + sec / cca_pkg::SEC_PER_MIN;
		sec  = sec % cca_pkg::SEC_PER_MIN;
		hrs  = hrs + mins / cca_pkg::MIN_PER_HOUR;
		mins = mins % cca_pkg::MIN_PER_HOUR;
		day  = day + hrs / cca_pkg::HOUR_PER_DAY;
		hrs  = hrs % cca_pkg::HOUR_PER_DAY;
		case (mon)
			4, 6, 9, 11: len = 30;
			2:           len = (yr % 4 == 0) ? cca_pkg::FEB_LEAP : 28;
			default:     len = 31;
		endcase
		// Only one month length is ever taken off, and months outside the
		// calendar count as 31 days long.
		if (day > len) begin
			day = day - len;
			if (mon >= cca_pkg::MONTHS) begin
				mon = 1;
				yr  = (yr >= cca_pkg::LAST_YEAR) ? 0 : yr + 1;
			end else begin
				mon = mon + 1;
			end
		end
		nxt.year   = 7'(yr);
		nxt.month  = 4'(mon);
		nxt.day    = 5'(day);
		nxt.hour   = 5'(hrs);
		nxt.minute = 6'(mins);
		nxt.second = 6'(sec);
		return nxt;
	endfunction

	function automatic string show_time(cca_pkg::time_t t);
		return $sformatf("%0d-%0d-%0d %0d:%0d:%0d",
			t.year, t.month, t.day, t.hour, t.minute, t.second);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cca_pkg::time_t seen;
		cca_pkg::time_t want;
		cca_pkg::time_t loaded;
		if (!arst_n) begin
			calendar_now = cca_pkg::RESET_TIME;
			expected_times.delete();
			error_total = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (result.valid && result.ready) begin
				seen = '{year: result.cur_year, month: result.cur_month,
					day: result.cur_day, hour: result.cur_hour,
					minute: result.cur_minute, second: result.cur_second};
				if (expected_times.size() == 0) begin
					error_total++;
					if (error_total <= 10)
						$display("%0t: result word with nothing expected, got %s",
							$time, show_time(seen));
				end else begin
					want = expected_times.pop_front();
					if (seen !== want) begin
						error_total++;
						if (error_total <= 10)
							$display("%0t: result mismatch, expected %s, got %s",
								$time, show_time(want), show_time(seen));
					end
				end
			end
			if (item.valid && item.ready) begin
				loaded = '{year: item.load_year, month: item.load_month,
					day: item.load_day, hour: item.load_hour,
					minute: item.load_minute, second: item.load_second};
				calendar_now = advance_calendar(calendar_now, item.kind, item.amount,
					loaded);
				expected_times.push_back(calendar_now);
			end
			fail_count <= error_total;
			pending    <= expected_times.size();
		end
	end

endmodule

// ===== dv/tb_calendar_clock_advance_core.sv =====
// ----------------------------------------------------------------------------
// Calendar clock advance core testbench
// Drives directed and random command words with random gaps and receiver
// stalls, and lets the checker beside the core predict and compare results.
// ----------------------------------------------------------------------------
module tb_calendar_clock_advance_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         RANDOM_WORDS  = 450;
	localparam int         HOLD_START    = 150;
	localparam int         HOLD_LEN      = 80;
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	bit   gaps_on;

	cca_item_if   item_ch();
	cca_result_if result_ch();

	calendar_clock_advance_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	cca_calendar_checker calendar_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_calendar_clock_advance_core: FAIL");
			$finish;
		end
	end

	function automatic cca_pkg::time_t calendar_at(int y, int mo, int d, int h, int mi,
		int s);
		cca_pkg::time_t t;
		t.year   = 7'(y);
		t.month  = 4'(mo);
		t.day    = 5'(d);
		t.hour   = 5'(h);
		t.minute = 6'(mi);
		t.second = 6'(s);
		return t;
	endfunction

	function automatic cca_pkg::time_t random_load();
		cca_pkg::time_t t;
		int             r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			t.year   = 7'($urandom);
			t.month  = 4'($urandom);
			t.day    = 5'($urandom);
			t.hour   = 5'($urandom);
			t.minute = 6'($urandom);
			t.second = 6'($urandom);
		end else if (r < 60) begin
			t.year   = 7'($urandom_range(0, 99));
			t.month  = 4'($urandom_range(1, 12));
			t.day    = 5'($urandom_range(27, 31));
			t.hour   = 5'($urandom_range(22, 23));
			t.minute = 6'($urandom_range(58, 59));
			t.second = 6'($urandom_range(45, 59));
		end else begin
			t.year   = 7'($urandom_range(0, 99));
			t.month  = 4'($urandom_range(1, 12));
			t.day    = 5'($urandom_range(1, 31));
			t.hour   = 5'($urandom_range(0, 23));
			t.minute = 6'($urandom_range(0, 59));
			t.second = 6'($urandom_range(0, 59));
		end
		return t;
	endfunction

	task automatic send_word(input logic [2:0] kind, input logic [7:0] amount,
		input cca_pkg::time_t load);
		int r;
		int n;
		item_ch.valid       <= 1'b1;
		item_ch.kind        <= kind;
		item_ch.amount      <= amount;
		item_ch.load_year   <= load.year;
		item_ch.load_month  <= load.month;
		item_ch.load_day    <= load.day;
		item_ch.load_hour   <= load.hour;
		item_ch.load_minute <= load.minute;
		item_ch.load_second <= load.second;
		do @(posedge clk); while (!item_ch.ready);
		n = 0;
		r = $urandom_range(0, 99);
		if (gaps_on && r >= 60)
			n = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (n > 0) begin
			item_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : receiver
		int cyc;
		int low_left;
		int r;
		cyc      = 0;
		low_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
				result_ch.ready <= 1'b0;
			end else if (low_left > 0) begin
				low_left--;
				result_ch.ready <= 1'b0;
			end else if (cyc >= 2000 && cyc < 2300) begin
				result_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					result_ch.ready <= 1'b1;
				end else begin
					result_ch.ready <= 1'b0;
					low_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 20);
				end
			end
		end
	end

	initial begin : stimulus
		int         r;
		logic [2:0] kind;
		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.kind        <= cca_pkg::KIND_TICK;
		item_ch.amount      <= '0;
		item_ch.load_year   <= '0;
		item_ch.load_month  <= '0;
		item_ch.load_day    <= '0;
		item_ch.load_hour   <= '0;
		item_ch.load_minute <= '0;
		item_ch.load_second <= '0;
		gaps_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_word(cca_pkg::KIND_TICK, 8'd0, '0);
		send_word(cca_pkg::KIND_ADD, 8'd0, '0);
		send_word(cca_pkg::KIND_ADD, 8'd255, '0);
		send_word(cca_pkg::KIND_TEN, 8'd0, '0);
		send_word(cca_pkg::KIND_HOUR, 8'd0, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, calendar_at(99, 12, 31, 23, 59, 59));
		send_word(cca_pkg::KIND_TICK, 8'd0, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, calendar_at(0, 2, 28, 23, 59, 55));
		send_word(cca_pkg::KIND_TEN, 8'd0, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, calendar_at(0, 2, 29, 23, 10, 5));
		send_word(cca_pkg::KIND_HOUR, 8'd0, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, calendar_at(1, 2, 28, 23, 59, 59));
		send_word(cca_pkg::KIND_ADD, 8'd1, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, calendar_at(1, 4, 30, 23, 59, 30));
		send_word(cca_pkg::KIND_ADD, 8'd30, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, calendar_at(127, 15, 31, 31, 63, 63));
		send_word(cca_pkg::KIND_ADD, 8'd255, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, '0);
		send_word(cca_pkg::KIND_TICK, 8'd255, '0);
		send_word(cca_pkg::KIND_LOAD, 8'd0, calendar_at(3, 2, 31, 10, 0, 0));
		send_word(cca_pkg::KIND_TEN, 8'd0, '0);
		send_word(KIND_SPARE_LO, 8'd255, '1);
		send_word(KIND_SPARE_HI, 8'd170, '1);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 200) begin
				item_ch.valid <= 1'b0;
				drain();
			end
			gaps_on = !(i >= 300 && i < 360);
			r = $urandom_range(0, 99);
			if (r < 15)
				kind = cca_pkg::KIND_LOAD;
			else if (r < 40)
				kind = cca_pkg::KIND_TICK;
			else if (r < 65)
				kind = cca_pkg::KIND_ADD;
			else if (r < 80)
				kind = cca_pkg::KIND_TEN;
			else if (r < 95)
				kind = cca_pkg::KIND_HOUR;
			else
				kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
			send_word(kind, 8'($urandom), random_load());
		end

		item_ch.valid <= 1'b0;
		drain();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_calendar_clock_advance_core: PASS");
		else
			$display("tb_calendar_clock_advance_core: FAIL");
		$finish;
	end

endmodule
